>>> rtl/core/ehc_pkg.sv
// shared types, codes and header positions for the ethernet frame classifier
`default_nettype none

package ehc_pkg;

    // captured header bytes: positions 12..23, 28..31 and 38..41
    localparam int unsigned NUM_CAP  = 20;
    // icmp type, code and checksum bytes behind the ipv4 header
    localparam int unsigned NUM_ICMP = 4;
    // frame record queue depth
    localparam int unsigned Q_DEPTH  = 2;
    // width used for length compares
    localparam int unsigned CMP_W    = 17;

    // indexes into the captured byte array
    localparam int unsigned CAP_ET_HI = 0;
    localparam int unsigned CAP_ET_LO = 1;
    localparam int unsigned CAP_B14   = 2;
    localparam int unsigned CAP_B15   = 3;
    localparam int unsigned CAP_B16   = 4;
    localparam int unsigned CAP_B17   = 5;
    localparam int unsigned CAP_B18   = 6;
    localparam int unsigned CAP_B19   = 7;
    localparam int unsigned CAP_B20   = 8;
    localparam int unsigned CAP_B21   = 9;
    localparam int unsigned CAP_B22   = 10;
    localparam int unsigned CAP_B23   = 11;
    localparam int unsigned CAP_SPA   = 12;
    localparam int unsigned CAP_TPA   = 16;

    // first byte of the ipv4 header
    localparam int unsigned IP_HDR_POS = 14;

    // ethertypes
    localparam logic [15:0] ETH_IPV4   = 16'h0800;
    localparam logic [15:0] ETH_ARP    = 16'h0806;
    localparam logic [15:0] ETH_MACSEC = 16'h88E5;

    // field values checked
    localparam logic [15:0] ARP_HTYPE_ETH = 16'h0001;
    localparam logic [15:0] ARP_OP_REQ    = 16'h0001;
    localparam logic [15:0] ARP_OP_REPLY  = 16'h0002;
    localparam logic [7:0]  ARP_HLEN      = 8'd6;
    localparam logic [7:0]  ARP_PLEN      = 8'd4;
    localparam logic [7:0]  IP_PROTO_ICMP = 8'd1;
    localparam logic [7:0]  SHORT_LEN_MASK = 8'h3F;

    // minimum lengths
    localparam logic [CMP_W-1:0] MIN_ETH    = CMP_W'(14);
    localparam logic [CMP_W-1:0] MIN_ARP    = CMP_W'(42);
    localparam logic [CMP_W-1:0] MIN_IPV4   = CMP_W'(34);
    localparam logic [CMP_W-1:0] MIN_ICMP   = CMP_W'(42);
    localparam logic [CMP_W-1:0] MIN_MACSEC = CMP_W'(36);
    localparam logic [CMP_W-1:0] MIN_IHL    = CMP_W'(20);
    // ethernet header plus icmp header
    localparam logic [CMP_W-1:0] IHL_SPAN   = CMP_W'(22);

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_MALFORMED = 3'd1;
    localparam logic [2:0] ST_TRUNC     = 3'd2;
    localparam logic [2:0] ST_UNKNOWN   = 3'd3;
    localparam logic [2:0] ST_UNSUP     = 3'd4;

    // protocol codes
    localparam logic [2:0] PR_UNKNOWN = 3'd0;
    localparam logic [2:0] PR_ARP     = 3'd1;
    localparam logic [2:0] PR_ICMP    = 3'd2;
    localparam logic [2:0] PR_MACSEC  = 3'd3;
    localparam logic [2:0] PR_IPV4    = 3'd4;

    // header bytes of one finished frame
    typedef struct packed {
        logic [NUM_CAP-1:0][7:0]  cap;
        logic [NUM_ICMP-1:0][7:0] icmp;
    } t_frame_rec;

    // classification result without the length
    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  protocol;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [15:0] half_a;
        logic [15:0] half_b;
        logic [7:0]  byte_a;
        logic [7:0]  byte_b;
        logic [7:0]  byte_c;
    } t_verdict;

    // frame position of each captured byte
    function automatic logic [6:0] cap_pos(input int unsigned k);
        logic [6:0] p;
        if (k < 12) begin
            p = 7'(12 + k);
        end else if (k < 16) begin
            p = 7'(16 + k);
        end else begin
            p = 7'(22 + k);
        end
        return p;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/ehc_front.sv
// front end: byte counter and header byte capture, one record per frame
`default_nettype none

module ehc_front #(
    parameter int unsigned LENGTH_BITS = 14
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire logic [7:0]             i_data_byte,
    input  wire logic                   i_last_byte,
    output logic                        o_in_stall,
    input  wire logic                   i_q_full,
    output logic                        o_push,
    output ehc_pkg::t_frame_rec         o_rec,
    output logic [LENGTH_BITS-1:0]      o_len
);

    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

    logic                                        accept;
    logic [LENGTH_BITS-1:0]                      r_count;
    logic [LENGTH_BITS-1:0]                      inc_count;
    logic [ehc_pkg::NUM_CAP-1:0][7:0]            r_cap;
    logic [ehc_pkg::NUM_CAP-1:0][7:0]            n_cap;
    logic [ehc_pkg::NUM_ICMP-1:0][7:0]           r_icmp;
    logic [ehc_pkg::NUM_ICMP-1:0][7:0]           n_icmp;
    logic [5:0]                                  ihl4;

    // stall only while the record queue is full
    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    // saturating count including the current byte
    assign inc_count = (r_count != COUNT_MAX) ? r_count + LENGTH_BITS'(1) : r_count;

    // fixed position header bytes
    for (genvar g = 0; g < ehc_pkg::NUM_CAP; g++) begin : g_cap
        assign n_cap[g] = (accept && (r_count == LENGTH_BITS'(ehc_pkg::cap_pos(g))))
                          ? i_data_byte : r_cap[g];
    end

    // icmp bytes sit behind the ipv4 header, whose length is known from byte 14
    assign ihl4 = {r_cap[ehc_pkg::CAP_B14][3:0], 2'b00};

    for (genvar g = 0; g < ehc_pkg::NUM_ICMP; g++) begin : g_icmp
        assign n_icmp[g] = (accept && (r_count == LENGTH_BITS'(ehc_pkg::IP_HDR_POS)
                            + LENGTH_BITS'(ihl4) + LENGTH_BITS'(g)))
                           ? i_data_byte : r_icmp[g];
    end

    // capture registers
    always_ff @(posedge i_clk) begin
        r_cap  <= n_cap;
        r_icmp <= n_icmp;
    end

    // byte counter, cleared after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= i_last_byte ? '0 : inc_count;
        end
    end

    // record for the finished frame includes the last byte itself
    assign o_push     = accept && i_last_byte;
    assign o_rec.cap  = n_cap;
    assign o_rec.icmp = n_icmp;
    assign o_len      = inc_count;

`ifndef SYNTH
    a_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_byte) |=> (r_count == '0))
        else $error("byte count not cleared after last byte");
`endif

endmodule

`default_nettype wire

>>> rtl/core/ehc_queue.sv
// two-entry register queue of frame records between front and back
`default_nettype none

module ehc_queue #(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data,
    input  wire logic             i_pop
);

    localparam int unsigned DEPTH = ehc_pkg::Q_DEPTH;
    localparam int unsigned PW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue fill count beyond depth");
    a_push_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full && !do_pop) |=> (r_cnt == $past(r_cnt) + CW'(1)))
        else $error("queue push not counted");
`endif

endmodule

`default_nettype wire

>>> rtl/core/ehc_back.sv
// back end: classification of one frame record and the output register
`default_nettype none

module ehc_back #(
    parameter int unsigned LENGTH_BITS = 14
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_q_valid,
    input  wire ehc_pkg::t_frame_rec    i_rec,
    input  wire logic [LENGTH_BITS-1:0] i_len,
    output logic                        o_q_pop,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output ehc_pkg::t_verdict           o_verdict,
    output logic [LENGTH_BITS-1:0]      o_len
);

    logic                           r_out_valid;
    ehc_pkg::t_verdict              r_verdict;
    logic [LENGTH_BITS-1:0]         r_len;
    ehc_pkg::t_verdict              v;
    logic [ehc_pkg::CMP_W-1:0]      lenx;
    logic [ehc_pkg::CMP_W-1:0]      ihl4;
    logic [15:0]                    etype;
    logic [15:0]                    oper;
    logic [31:0]                    pn;
    logic [7:0]                     b14;
    logic [7:0]                     ty;
    logic [7:0]                     ttl;
    logic                           bad;

    assign lenx  = ehc_pkg::CMP_W'(i_len);
    assign etype = {i_rec.cap[ehc_pkg::CAP_ET_HI], i_rec.cap[ehc_pkg::CAP_ET_LO]};
    assign b14   = i_rec.cap[ehc_pkg::CAP_B14];
    assign ihl4  = ehc_pkg::CMP_W'({b14[3:0], 2'b00});
    assign oper  = {i_rec.cap[ehc_pkg::CAP_B20], i_rec.cap[ehc_pkg::CAP_B21]};
    assign pn    = {i_rec.cap[ehc_pkg::CAP_B16], i_rec.cap[ehc_pkg::CAP_B17],
                    i_rec.cap[ehc_pkg::CAP_B18], i_rec.cap[ehc_pkg::CAP_B19]};
    assign ty    = i_rec.icmp[0];
    assign ttl   = i_rec.cap[ehc_pkg::CAP_B22];

    // verdict from ethertype, lengths and field rules
    always_comb begin
        v   = '0;
        bad = 1'b0;
        if (lenx < ehc_pkg::MIN_ETH) begin
            v.status = ehc_pkg::ST_TRUNC;
        end else begin
            case (etype)
                ehc_pkg::ETH_ARP: begin
                    v.protocol = ehc_pkg::PR_ARP;
                    if (lenx < ehc_pkg::MIN_ARP) begin
                        v.status = ehc_pkg::ST_TRUNC;
                    end else begin
                        v.word_a = {i_rec.cap[ehc_pkg::CAP_SPA],
                                    i_rec.cap[ehc_pkg::CAP_SPA + 1],
                                    i_rec.cap[ehc_pkg::CAP_SPA + 2],
                                    i_rec.cap[ehc_pkg::CAP_SPA + 3]};
                        v.word_b = {i_rec.cap[ehc_pkg::CAP_TPA],
                                    i_rec.cap[ehc_pkg::CAP_TPA + 1],
                                    i_rec.cap[ehc_pkg::CAP_TPA + 2],
                                    i_rec.cap[ehc_pkg::CAP_TPA + 3]};
                        v.half_a = oper;
                        v.byte_a = i_rec.cap[ehc_pkg::CAP_B18];
                        v.byte_b = i_rec.cap[ehc_pkg::CAP_B19];
                        if ({b14, i_rec.cap[ehc_pkg::CAP_B15]} != ehc_pkg::ARP_HTYPE_ETH) begin
                            bad = 1'b1;
                        end
                        if ({i_rec.cap[ehc_pkg::CAP_B16], i_rec.cap[ehc_pkg::CAP_B17]}
                            != ehc_pkg::ETH_IPV4) begin
                            bad = 1'b1;
                        end
                        if (i_rec.cap[ehc_pkg::CAP_B18] != ehc_pkg::ARP_HLEN ||
                            i_rec.cap[ehc_pkg::CAP_B19] != ehc_pkg::ARP_PLEN) begin
                            bad = 1'b1;
                        end
                        if (oper != ehc_pkg::ARP_OP_REQ && oper != ehc_pkg::ARP_OP_REPLY) begin
                            bad = 1'b1;
                        end
                        v.status = bad ? ehc_pkg::ST_MALFORMED : ehc_pkg::ST_OK;
                    end
                end
                ehc_pkg::ETH_IPV4: begin
                    if (lenx < ehc_pkg::MIN_IPV4 ||
                        i_rec.cap[ehc_pkg::CAP_B23] != ehc_pkg::IP_PROTO_ICMP) begin
                        v.status   = ehc_pkg::ST_UNSUP;
                        v.protocol = ehc_pkg::PR_IPV4;
                    end else begin
                        v.protocol = ehc_pkg::PR_ICMP;
                        if (lenx < ehc_pkg::MIN_ICMP) begin
                            v.status = ehc_pkg::ST_TRUNC;
                        end else if (ihl4 < ehc_pkg::MIN_IHL ||
                                     ehc_pkg::IHL_SPAN + ihl4 > lenx) begin
                            v.status = ehc_pkg::ST_MALFORMED;
                        end else begin
                            v.half_a = {i_rec.icmp[2], i_rec.icmp[3]};
                            v.half_b = {i_rec.cap[ehc_pkg::CAP_B16],
                                        i_rec.cap[ehc_pkg::CAP_B17]};
                            v.byte_a = ty;
                            v.byte_b = i_rec.icmp[1];
                            v.byte_c = ttl;
                            if (ty inside {[8'd19:8'd29]}) begin
                                bad = 1'b1;
                            end
                            if (ttl == 8'd0) begin
                                bad = 1'b1;
                            end
                            v.status = bad ? ehc_pkg::ST_MALFORMED : ehc_pkg::ST_OK;
                        end
                    end
                end
                ehc_pkg::ETH_MACSEC: begin
                    v.protocol = ehc_pkg::PR_MACSEC;
                    if (lenx < ehc_pkg::MIN_MACSEC) begin
                        v.status = ehc_pkg::ST_TRUNC;
                    end else begin
                        v.word_a = pn;
                        v.byte_a = b14;
                        v.byte_b = i_rec.cap[ehc_pkg::CAP_B15] & ehc_pkg::SHORT_LEN_MASK;
                        v.byte_c = {7'd0, b14[5]};
                        if (b14[7]) begin
                            bad = 1'b1;
                        end
                        if (pn == 32'd0) begin
                            bad = 1'b1;
                        end
                        v.status = bad ? ehc_pkg::ST_MALFORMED : ehc_pkg::ST_OK;
                    end
                end
                default: begin
                    v.status = ehc_pkg::ST_UNKNOWN;
                end
            endcase
        end
    end

    // take a record whenever the output register is free or being drained
    assign o_q_pop = i_q_valid && (!r_out_valid || !i_out_stall);

    // output register payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_verdict <= v;
            r_len     <= i_len;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;
    assign o_len       = r_len;

`ifndef SYNTH
    a_trunc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_verdict.status == ehc_pkg::ST_TRUNC) |->
        (r_verdict.word_a == '0 && r_verdict.word_b == '0 &&
         r_verdict.half_a == '0 && r_verdict.half_b == '0))
        else $error("truncated verdict carries extracted fields");
    a_unknown_proto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_verdict.status == ehc_pkg::ST_UNKNOWN) |->
        (r_verdict.protocol == ehc_pkg::PR_UNKNOWN))
        else $error("unknown ethertype with a protocol set");
`endif

endmodule

`default_nettype wire

>>> rtl/core/ethernet_arp_icmp_macsec_classifier_core.sv
// top level: ethernet frame classifier for arp, ipv4 icmp and macsec
// takes one frame byte per cycle while the input is not stalled, with no gaps needed between frames
// the record of the last byte is queued, then classified into the registered verdict output
// a two-entry record queue lets the byte input run while the verdict is stalled
// input stalls only while that queue is full; one verdict per frame, one per cycle at most
// synchronous active-low reset clears the byte count, the queue and the output valid
`default_nettype none

module ethernet_arp_icmp_macsec_classifier_core #(
    parameter int unsigned LENGTH_BITS = 14
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [7:0]             i_data_byte,
    input  wire logic                   i_last_byte,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [2:0]                  o_status,
    output logic [2:0]                  o_protocol,
    output logic [LENGTH_BITS-1:0]      o_frame_length,
    output logic [31:0]                 o_word_a,
    output logic [31:0]                 o_word_b,
    output logic [15:0]                 o_half_a,
    output logic [15:0]                 o_half_b,
    output logic [7:0]                  o_byte_a,
    output logic [7:0]                  o_byte_b,
    output logic [7:0]                  o_byte_c
);

    localparam int unsigned REC_W = $bits(ehc_pkg::t_frame_rec);
    localparam int unsigned QW    = REC_W + LENGTH_BITS;

    logic                       q_full;
    logic                       f_push;
    ehc_pkg::t_frame_rec        f_rec;
    logic [LENGTH_BITS-1:0]     f_len;
    logic                       q_valid;
    logic [QW-1:0]              q_data;
    logic                       q_pop;
    ehc_pkg::t_verdict          verdict;

    // byte capture
    ehc_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_in_stall  (o_in_stall),
        .i_q_full    (q_full),
        .o_push      (f_push),
        .o_rec       (f_rec),
        .o_len       (f_len)
    );

    // frame record queue
    ehc_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_rec, f_len}),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    // classification and output register
    ehc_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_rec       (ehc_pkg::t_frame_rec'(q_data[QW-1 -: REC_W])),
        .i_len       (q_data[LENGTH_BITS-1:0]),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_verdict   (verdict),
        .o_len       (o_frame_length)
    );

    // result fields
    assign o_status   = verdict.status;
    assign o_protocol = verdict.protocol;
    assign o_word_a   = verdict.word_a;
    assign o_word_b   = verdict.word_b;
    assign o_half_a   = verdict.half_a;
    assign o_half_b   = verdict.half_b;
    assign o_byte_a   = verdict.byte_a;
    assign o_byte_b   = verdict.byte_b;
    assign o_byte_c   = verdict.byte_c;

endmodule

`default_nettype wire

>>> dv/ehc_verdict_checker.sv
// checker for the frame classifier: predicts each frame verdict from the accepted bytes and compares
module ehc_verdict_checker #(
    parameter int unsigned LENGTH_BITS = 14
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_last_byte,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [2:0]             i_status,
    input  logic [2:0]             i_protocol,
    input  logic [LENGTH_BITS-1:0] i_frame_length,
    input  logic [31:0]            i_word_a,
    input  logic [31:0]            i_word_b,
    input  logic [15:0]            i_half_a,
    input  logic [15:0]            i_half_b,
    input  logic [7:0]             i_byte_a,
    input  logic [7:0]             i_byte_b,
    input  logic [7:0]             i_byte_c,
    output int                     o_err_count,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ehc_pkg::*;

    localparam int unsigned HDR_DEPTH   = 82;
    localparam int unsigned COUNT_MAX   = (1 << LENGTH_BITS) - 1;
    localparam int unsigned MAX_REPORTS = 10;
    localparam logic [7:0]  MACSEC_V_BIT  = 8'h80;
    localparam logic [7:0]  ICMP_BAD_LO   = 8'd18;
    localparam logic [7:0]  ICMP_BAD_HI   = 8'd30;

    typedef struct packed {
        logic [2:0]             status;
        logic [2:0]             protocol;
        logic [LENGTH_BITS-1:0] frame_length;
        logic [31:0]            word_a;
        logic [31:0]            word_b;
        logic [15:0]            half_a;
        logic [15:0]            half_b;
        logic [7:0]             byte_a;
        logic [7:0]             byte_b;
        logic [7:0]             byte_c;
    } frame_verdict_t;

    logic [7:0]     hdr_bytes [HDR_DEPTH];
    int unsigned    bytes_in_frame = 0;
    frame_verdict_t verdict_q [$];
    int unsigned    verdicts_seen = 0;
    int             err_count = 0;
    int             pending = 0;

    assign o_err_count = err_count;
    assign o_pending   = pending;

    // header byte reads, zero past the stored part
    function automatic logic [7:0] rd8(int unsigned pos);
        return (pos < HDR_DEPTH) ? hdr_bytes[pos] : 8'h00;
    endfunction

    function automatic logic [15:0] rd16(int unsigned pos);
        return {rd8(pos), rd8(pos + 1)};
    endfunction

    function automatic logic [31:0] rd32(int unsigned pos);
        return {rd16(pos), rd16(pos + 2)};
    endfunction

    // verdict for a finished frame of len bytes
    function automatic frame_verdict_t classify_frame(int unsigned len);
        frame_verdict_t v;
        logic [15:0]    etype;
        int unsigned    ihl;
        logic [7:0]     ihl_byte;
        logic [7:0]     icmp_ty;
        logic [7:0]     tci;
        bit             bad;
        v = '0;
        bad = 1'b0;
        v.frame_length = LENGTH_BITS'(len);
        if (len < MIN_ETH) begin
            v.status = ST_TRUNC;
            return v;
        end
        etype = rd16(12);
        if (etype == ETH_ARP) begin
            v.protocol = PR_ARP;
            if (len < MIN_ARP) begin
                v.status = ST_TRUNC;
                return v;
            end
            v.word_a = rd32(28);
            v.word_b = rd32(38);
            v.half_a = rd16(20);
            v.byte_a = rd8(18);
            v.byte_b = rd8(19);
            if (rd16(14) != ARP_HTYPE_ETH || rd16(16) != ETH_IPV4) bad = 1'b1;
            if (v.byte_a != ARP_HLEN || v.byte_b != ARP_PLEN) bad = 1'b1;
            if (v.half_a != ARP_OP_REQ && v.half_a != ARP_OP_REPLY) bad = 1'b1;
            v.status = bad ? ST_MALFORMED : ST_OK;
        end else if (etype == ETH_IPV4) begin
            if (len < MIN_IPV4 || rd8(23) != IP_PROTO_ICMP) begin
                v.status   = ST_UNSUP;
                v.protocol = PR_IPV4;
                return v;
            end
            v.protocol = PR_ICMP;
            if (len < MIN_ICMP) begin
                v.status = ST_TRUNC;
                return v;
            end
            ihl_byte = rd8(IP_HDR_POS);
            ihl = ihl_byte[3:0] * 4;
            if (ihl < MIN_IHL || IHL_SPAN + ihl > len) begin
                v.status = ST_MALFORMED;
                return v;
            end
            icmp_ty  = rd8(14 + ihl);
            v.half_a = rd16(16 + ihl);
            v.half_b = rd16(16);
            v.byte_a = icmp_ty;
            v.byte_b = rd8(15 + ihl);
            v.byte_c = rd8(22);
            if (icmp_ty > ICMP_BAD_LO && icmp_ty < ICMP_BAD_HI) bad = 1'b1;
            if (v.byte_c == 8'd0) bad = 1'b1;
            v.status = bad ? ST_MALFORMED : ST_OK;
        end else if (etype == ETH_MACSEC) begin
            v.protocol = PR_MACSEC;
            if (len < MIN_MACSEC) begin
                v.status = ST_TRUNC;
                return v;
            end
            tci      = rd8(14);
            v.word_a = rd32(16);
            v.byte_a = tci;
            v.byte_b = rd8(15) & SHORT_LEN_MASK;
            v.byte_c = {7'd0, tci[5]};
            if ((tci & MACSEC_V_BIT) != 8'd0) bad = 1'b1;
            if (v.word_a == 32'd0) bad = 1'b1;
            v.status = bad ? ST_MALFORMED : ST_OK;
        end else begin
            v.status = ST_UNKNOWN;
        end
        return v;
    endfunction

    // one field of a verdict against its prediction
    task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v) begin
            if (err_count < MAX_REPORTS) begin
                $display("%0t verdict %0d: %s expected %0h, got %0h",
                         $time, verdicts_seen, name, want_v, got_v);
            end
            err_count++;
        end
    endtask

    // watch both channels at the rising edge
    always @(posedge i_clk) begin : watch
        frame_verdict_t got;
        frame_verdict_t want;
        if (!i_rst_n) begin
            bytes_in_frame = 0;
            verdict_q.delete();
        end else begin
            // verdict leaving the block
            if (i_out_valid && !i_out_stall) begin
                got = {i_status, i_protocol, i_frame_length, i_word_a, i_word_b,
                       i_half_a, i_half_b, i_byte_a, i_byte_b, i_byte_c};
                if (verdict_q.size() == 0) begin
                    if (err_count < MAX_REPORTS) begin
                        $display("%0t verdict %0d: no frame waiting, got status %0d",
                                 $time, verdicts_seen, got.status);
                    end
                    err_count++;
                end else begin
                    want = verdict_q.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("protocol", want.protocol, got.protocol);
                    check_field("frame_length", want.frame_length, got.frame_length);
                    check_field("word_a", want.word_a, got.word_a);
                    check_field("word_b", want.word_b, got.word_b);
                    check_field("half_a", want.half_a, got.half_a);
                    check_field("half_b", want.half_b, got.half_b);
                    check_field("byte_a", want.byte_a, got.byte_a);
                    check_field("byte_b", want.byte_b, got.byte_b);
                    check_field("byte_c", want.byte_c, got.byte_c);
                end
                verdicts_seen++;
            end
            // frame byte entering the block
            if (i_in_valid && !i_in_stall) begin
                if (bytes_in_frame < HDR_DEPTH) hdr_bytes[bytes_in_frame] = i_data_byte;
                if (bytes_in_frame < COUNT_MAX) bytes_in_frame++;
                if (i_last_byte) begin
                    verdict_q.push_back(classify_frame(bytes_in_frame));
                    bytes_in_frame = 0;
                end
            end
        end
        pending = verdict_q.size();
    end

endmodule

>>> dv/tb_ethernet_arp_icmp_macsec_classifier_core.sv
// testbench top for the frame classifier: frame stimulus, channel idling and final verdict
module tb_ethernet_arp_icmp_macsec_classifier_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ehc_pkg::*;

    localparam int unsigned LENGTH_BITS     = 14;
    localparam int unsigned HOLD_CYCLES     = 300;
    localparam int unsigned WATCHDOG_LIMIT  = 3000;
    localparam int unsigned DRAIN_CYCLES    = 20;
    localparam int unsigned RANDOM_FRAMES   = 4;
    localparam int unsigned PRESSURE_FRAMES = 8;

    typedef enum {FK_ARP, FK_ICMP, FK_IPV4, FK_MACSEC, FK_UNKNOWN, FK_NOISE} frame_kind_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [7:0]             i_data_byte;
    logic                   i_last_byte;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [2:0]             o_status;
    logic [2:0]             o_protocol;
    logic [LENGTH_BITS-1:0] o_frame_length;
    logic [31:0]            o_word_a;
    logic [31:0]            o_word_b;
    logic [15:0]            o_half_a;
    logic [15:0]            o_half_b;
    logic [7:0]             o_byte_a;
    logic [7:0]             o_byte_b;
    logic [7:0]             o_byte_c;

    int          err_count;
    int          pending;
    int          in_idle_pct = 0;
    int          out_stall_pct = 0;
    bit          hold_req = 1'b0;
    int unsigned quiet_cycles = 0;
    logic [7:0]  frame_bytes [$];

    ethernet_arp_icmp_macsec_classifier_core #(
        .LENGTH_BITS(LENGTH_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_protocol     (o_protocol),
        .o_frame_length (o_frame_length),
        .o_word_a       (o_word_a),
        .o_word_b       (o_word_b),
        .o_half_a       (o_half_a),
        .o_half_b       (o_half_b),
        .o_byte_a       (o_byte_a),
        .o_byte_b       (o_byte_b),
        .o_byte_c       (o_byte_c)
    );

    ehc_verdict_checker #(
        .LENGTH_BITS(LENGTH_BITS)
    ) verdict_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_status       (o_status),
        .i_protocol     (o_protocol),
        .i_frame_length (o_frame_length),
        .i_word_a       (o_word_a),
        .i_word_b       (o_word_b),
        .i_half_a       (o_half_a),
        .i_half_b       (o_half_b),
        .i_byte_a       (o_byte_a),
        .i_byte_b       (o_byte_b),
        .i_byte_c       (o_byte_c),
        .o_err_count    (err_count),
        .o_pending      (pending)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // verdict receiver: random stalls, or one long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_out_stall = ($urandom_range(99) < out_stall_pct);
        end
    end

    // watchdog on cycles with no traffic on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // frame building helpers, writes past the frame end are dropped
    function automatic void set_byte(int unsigned pos, logic [7:0] val);
        if (pos < frame_bytes.size()) frame_bytes[pos] = val;
    endfunction

    function automatic void set16(int unsigned pos, logic [15:0] val);
        set_byte(pos, val[15:8]);
        set_byte(pos + 1, val[7:0]);
    endfunction

    function automatic void set32(int unsigned pos, logic [31:0] val);
        set16(pos, val[31:16]);
        set16(pos + 2, val[15:0]);
    endfunction

    // ipv4 header length, icmp type and ttl
    function automatic void set_icmp(int unsigned ihl, logic [7:0] icmp_type, logic [7:0] ttl);
        set_byte(IP_HDR_POS, {4'h4, 4'(ihl)});
        if (ihl >= 5) set_byte(IP_HDR_POS + ihl * 4, icmp_type);
        set_byte(22, ttl);
    endfunction

    function automatic void flip_bit(int unsigned lo, int unsigned hi);
        int unsigned pos;
        pos = $urandom_range(hi, lo);
        if (pos < frame_bytes.size()) frame_bytes[pos] ^= 8'(1 << $urandom_range(7));
    endfunction

    // random bytes of length n with a well-formed header for the kind, none for noise
    function automatic void build_frame(frame_kind_t kind, int unsigned n);
        logic [15:0] etype;
        logic [31:0] pn;
        logic [7:0]  proto;
        frame_bytes.delete();
        repeat (n) frame_bytes.push_back(8'($urandom));
        case (kind)
            FK_ARP: begin
                set16(12, ETH_ARP);
                set16(14, ARP_HTYPE_ETH);
                set16(16, ETH_IPV4);
                set_byte(18, ARP_HLEN);
                set_byte(19, ARP_PLEN);
                set16(20, $urandom_range(1) ? ARP_OP_REPLY : ARP_OP_REQ);
            end
            FK_ICMP: begin
                set16(12, ETH_IPV4);
                set_byte(23, IP_PROTO_ICMP);
                set_icmp(5, $urandom_range(1) ? 8'd8 : 8'd0, 8'($urandom_range(255, 1)));
            end
            FK_IPV4: begin
                set16(12, ETH_IPV4);
                proto = 8'($urandom);
                if (proto == IP_PROTO_ICMP) proto = 8'd0;
                set_byte(23, proto);
            end
            FK_MACSEC: begin
                set16(12, ETH_MACSEC);
                set_byte(14, 8'($urandom_range(127)));
                pn = $urandom;
                if (pn == 32'd0) pn = 32'd1;
                set32(16, pn);
            end
            FK_UNKNOWN: begin
                etype = 16'($urandom);
                if (etype == ETH_ARP || etype == ETH_IPV4 || etype == ETH_MACSEC) begin
                    etype ^= 16'h0001;
                end
                set16(12, etype);
            end
            default: begin
            end
        endcase
    endfunction

    // one random frame, mostly well-formed, some truncated or damaged
    function automatic void random_frame();
        int unsigned pick;
        int unsigned n;
        int unsigned ihl;
        int unsigned need;
        logic [7:0]  icmp_ty;
        logic [7:0]  ttl;
        pick = $urandom_range(99);
        if (pick < 20) begin
            n = ($urandom_range(6) == 0) ? $urandom_range(41, 14) : $urandom_range(70, 42);
            build_frame(FK_ARP, n);
            if ($urandom_range(4) == 0) flip_bit(14, 21);
        end else if (pick < 45) begin
            ihl = ($urandom_range(3) == 0) ? $urandom_range(15) : 5;
            need = 22 + ((ihl * 4 < 20) ? 20 : ihl * 4);
            n = ($urandom_range(9) == 0) ? $urandom_range(need, 14) : need + $urandom_range(20);
            icmp_ty = ($urandom_range(3) == 0) ? 8'($urandom) : ($urandom_range(1) ? 8'd8 : 8'd0);
            ttl = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
            build_frame(FK_ICMP, n);
            set_icmp(ihl, icmp_ty, ttl);
        end else if (pick < 55) begin
            build_frame(FK_IPV4, $urandom_range(80, 14));
        end else if (pick < 72) begin
            n = ($urandom_range(6) == 0) ? $urandom_range(35, 14) : $urandom_range(70, 36);
            build_frame(FK_MACSEC, n);
            if ($urandom_range(4) == 0) flip_bit(14, 19);
            if ($urandom_range(9) == 0) set32(16, 32'd0);
        end else if (pick < 80) begin
            build_frame(FK_UNKNOWN, $urandom_range(70, 14));
        end else if (pick < 92) begin
            build_frame(FK_NOISE, $urandom_range(100, 14));
        end else begin
            build_frame(FK_NOISE, $urandom_range(13, 1));
        end
    endfunction

    // one request on the byte channel, with random idle cycles in front
    task automatic send_byte(logic [7:0] b, logic last);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_data_byte = b;
        i_last_byte = last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // sender pause until every verdict is back
    task automatic wait_drain();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // stimulus
    initial begin
        int unsigned rnd_frames;
        rnd_frames  = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_data_byte = 8'h00;
        i_last_byte = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // no idling on either side
        in_idle_pct   = 0;
        out_stall_pct = 0;

        // shortest frames and a bare ethernet header
        build_frame(FK_NOISE, 1);
        frame_bytes[0] = 8'h00;
        send_frame();
        build_frame(FK_NOISE, 13);
        foreach (frame_bytes[i]) frame_bytes[i] = 8'hFF;
        send_frame();
        build_frame(FK_UNKNOWN, 14);
        set16(12, 16'hFFFF);
        send_frame();

        // arp: truncated, good request, broken header fields
        build_frame(FK_ARP, 41);
        send_frame();
        build_frame(FK_ARP, 42);
        set16(20, ARP_OP_REQ);
        set32(28, 32'h0000_0000);
        set32(38, 32'hFFFF_FFFF);
        send_frame();
        build_frame(FK_ARP, 42);
        set16(14, 16'h0002);
        set16(20, 16'h0003);
        send_frame();
        build_frame(FK_ARP, 42);
        set16(16, 16'h86DD);
        set_byte(18, 8'd5);
        set_byte(19, 8'd3);
        set16(20, 16'hFFFF);
        send_frame();

        // sender idles often
        in_idle_pct   = 57;
        out_stall_pct = 0;

        // ipv4 left unsupported: an icmp frame too short for the ipv4 header, and protocol 6
        build_frame(FK_ICMP, 33);
        send_frame();
        build_frame(FK_IPV4, 34);
        set_byte(23, 8'd6);
        send_frame();

        // icmp: truncated, header length bounds, type and ttl rules
        build_frame(FK_ICMP, 41);
        send_frame();
        build_frame(FK_ICMP, 42);
        set_icmp(4, 8'd8, 8'd64);
        send_frame();
        build_frame(FK_ICMP, 82);
        set_icmp(15, 8'd0, 8'd255);
        send_frame();
        build_frame(FK_ICMP, 42);
        set_icmp(5, 8'd8, 8'd64);
        send_frame();
        build_frame(FK_ICMP, 42);
        set_icmp(5, 8'd19, 8'd1);
        send_frame();
        build_frame(FK_ICMP, 42);
        set_icmp(5, 8'd29, 8'd0);
        send_frame();

        // receiver stalls often
        in_idle_pct   = 0;
        out_stall_pct = 57;

        // macsec: truncated, good with sc bit, v bit set, zero packet number
        build_frame(FK_MACSEC, 35);
        send_frame();
        build_frame(FK_MACSEC, 36);
        set_byte(14, 8'h20);
        set_byte(15, 8'hFF);
        set32(16, 32'd1);
        send_frame();
        build_frame(FK_MACSEC, 36);
        set_byte(14, 8'hFF);
        set32(16, 32'hFFFF_FFFF);
        send_frame();
        build_frame(FK_MACSEC, 36);
        set32(16, 32'd0);
        send_frame();

        // both sides idle now and then
        in_idle_pct   = 12;
        out_stall_pct = 12;

        // receiver holds off while short frames keep coming
        hold_req    = 1'b1;
        in_idle_pct = 0;
        repeat (PRESSURE_FRAMES) begin
            build_frame(FK_NOISE, $urandom_range(4, 1));
            send_frame();
        end
        wait_drain();
        in_idle_pct = 12;

        // random frames
        while (rnd_frames < RANDOM_FRAMES) begin
            random_frame();
            send_frame();
            rnd_frames++;
        end

        wait_drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (err_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/ehc_pkg.sv
rtl/core/ehc_front.sv
rtl/core/ehc_queue.sv
rtl/core/ehc_back.sv
rtl/core/ethernet_arp_icmp_macsec_classifier_core.sv
dv/ehc_verdict_checker.sv
dv/tb_ethernet_arp_icmp_macsec_classifier_core.sv
